### hdl/ttt_pkg.sv
package ttt_pkg;

    // Default table depth
    localparam int TABLE_DEPTH_DEF = 16;

    // Field widths
    localparam int MODE_W = 3;
    localparam int KIND_W = 3;
    localparam int ID_W   = 32;
    localparam int DLY_W  = 32;
    localparam int PER_W  = 31;
    localparam int REM_W  = 40;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_ONESHOT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PERIODIC = 3'd1;
    localparam logic [MODE_W-1:0] MODE_CANCEL   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TICK     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DRAIN    = 3'd4;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_SCHED  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CANCEL = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DONE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FULL   = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic sched;
        logic eval;
        logic post;
        logic finish;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              scan_empty;
        logic              scan_last;
    } stat_t;

    // Clamp a one-bit-grown sum back to the remaining-time range
    function automatic logic signed [REM_W-1:0] sat_rem(input logic signed [REM_W:0] v);
        logic signed [REM_W-1:0] r;
        if (v[REM_W] != v[REM_W-1]) begin
            r = v[REM_W] ? {1'b1, {(REM_W-1){1'b0}}} : {1'b0, {(REM_W-1){1'b1}}};
        end else begin
            r = v[REM_W-1:0];
        end
        return r;
    endfunction

endpackage

### hdl/ttt_ctrl.sv
module ttt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  ttt_pkg::stat_t stat,
    output ttt_pkg::cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_RD       = 3'd2;
    localparam logic [2:0] ST_EVAL     = 3'd3;
    localparam logic [2:0] ST_POST     = 3'd4;
    localparam logic [2:0] ST_FINISH   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (stat.mode) inside
                    ttt_pkg::MODE_ONESHOT, ttt_pkg::MODE_PERIODIC:
                    begin
                        cmd.sched  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    ttt_pkg::MODE_CANCEL, ttt_pkg::MODE_TICK, ttt_pkg::MODE_DRAIN:
                    begin
                        state_next = stat.scan_empty ? ST_FINISH : ST_RD;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_RD:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (stat.mode == ttt_pkg::MODE_TICK)
                begin
                    state_next = ST_POST;
                end
                else
                begin
                    state_next = stat.scan_last ? ST_FINISH : ST_RD;
                end
            end
            ST_POST:
            begin
                // read pointer already advanced in the eval cycle
                cmd.post   = 1'b1;
                state_next = stat.scan_empty ? ST_FINISH : ST_RD;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### hdl/ttt_dp.sv
module ttt_dp #(
    parameter int TABLE_DEPTH = ttt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic        [ttt_pkg::MODE_W-1:0]  mode,
    input  logic signed [ttt_pkg::DLY_W-1:0]   delay,
    input  logic        [ttt_pkg::PER_W-1:0]   period,
    input  logic        [ttt_pkg::ID_W-1:0]    cancel_id,
    input  logic        [ttt_pkg::PER_W-1:0]   elapsed,
    input  ttt_pkg::cmd_t                      cmd,
    output ttt_pkg::stat_t                     stat,
    output logic                               result_valid,
    output logic        [ttt_pkg::KIND_W-1:0]  kind,
    output logic        [ttt_pkg::ID_W-1:0]    task_id,
    output logic                               found,
    output logic                               last
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int REM_W = ttt_pkg::REM_W;
    localparam int PER_W = ttt_pkg::PER_W;
    localparam int ID_W  = ttt_pkg::ID_W;
    localparam int KIND_W = ttt_pkg::KIND_W;

    // Latched transaction fields
    logic        [ttt_pkg::MODE_W-1:0] mode_reg;
    logic signed [ttt_pkg::DLY_W-1:0]  delay_reg;
    logic        [PER_W-1:0]           period_reg;
    logic        [ID_W-1:0]            cid_reg;
    logic        [PER_W-1:0]           elapsed_reg;

    // Table control
    logic [CNT_W-1:0] count_reg;
    logic [ID_W-1:0]  next_id_reg;
    logic [CNT_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] wr_ptr_reg;
    logic             found_reg;
    logic             fire_reg;

    // Entry held between eval and post
    logic        [ID_W-1:0]  hold_id_reg;
    logic        [PER_W-1:0] hold_per_reg;
    logic signed [REM_W-1:0] hold_rem_reg;

    // Entry storage and registered read data
    logic        [ID_W-1:0]  mem_id  [TABLE_DEPTH];
    logic signed [REM_W-1:0] mem_rem [TABLE_DEPTH];
    logic        [PER_W-1:0] mem_per [TABLE_DEPTH];
    logic        [ID_W-1:0]  rdata_id_reg;
    logic signed [REM_W-1:0] rdata_rem_reg;
    logic        [PER_W-1:0] rdata_per_reg;

    // Result register
    logic              res_valid_reg;
    logic [KIND_W-1:0] res_kind_reg;
    logic [ID_W-1:0]   res_id_reg;
    logic              res_found_reg;
    logic              res_last_reg;
    logic              res_valid_next;
    logic [KIND_W-1:0] res_kind_next;
    logic [ID_W-1:0]   res_id_next;
    logic              res_found_next;
    logic              res_last_next;

    logic                    full;
    logic                    is_tick;
    logic                    is_cancel;
    logic                    is_drain;
    logic signed [REM_W:0]   tick_sub;
    logic signed [REM_W-1:0] tick_rem;
    logic                    tick_fire;
    logic signed [REM_W:0]   post_sum;
    logic signed [REM_W-1:0] post_rem;
    logic                    id_hit;
    logic                    cancel_skip;

    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic [ID_W-1:0]         wid;
    logic signed [REM_W-1:0] wrem;
    logic [PER_W-1:0]        wper;

    assign full      = (count_reg == CNT_W'(TABLE_DEPTH));
    assign is_tick   = (mode_reg == ttt_pkg::MODE_TICK);
    assign is_cancel = (mode_reg == ttt_pkg::MODE_CANCEL);
    assign is_drain  = (mode_reg == ttt_pkg::MODE_DRAIN);

    // Tick arithmetic: subtract elapsed, later add the period back
    assign tick_sub  = {rdata_rem_reg[REM_W-1], rdata_rem_reg}
                     - $signed({{(REM_W+1-PER_W){1'b0}}, elapsed_reg});
    assign tick_rem  = ttt_pkg::sat_rem(tick_sub);
    assign tick_fire = tick_rem[REM_W-1] | (tick_rem == '0);
    assign post_sum  = {hold_rem_reg[REM_W-1], hold_rem_reg}
                     + $signed({{(REM_W+1-PER_W){1'b0}}, hold_per_reg});
    assign post_rem  = ttt_pkg::sat_rem(post_sum);

    // Cancel drops only the first match
    assign id_hit      = (rdata_id_reg == cid_reg);
    assign cancel_skip = id_hit && !found_reg;

    // Status to controller
    assign stat.mode       = mode_reg;
    assign stat.scan_empty = (rd_ptr_reg == count_reg);
    assign stat.scan_last  = (CNT_W'(rd_ptr_reg + 1'b1) == count_reg);

    // Write port selection
    always_comb
    begin
        we    = 1'b0;
        waddr = wr_ptr_reg[IDX_W-1:0];
        wid   = rdata_id_reg;
        wrem  = rdata_rem_reg;
        wper  = rdata_per_reg;
        if (cmd.sched && !full)
        begin
            we    = 1'b1;
            waddr = count_reg[IDX_W-1:0];
            wid   = next_id_reg;
            if (mode_reg == ttt_pkg::MODE_ONESHOT)
            begin
                wrem = REM_W'(delay_reg);
                wper = '0;
            end
            else
            begin
                wrem = delay_reg[ttt_pkg::DLY_W-1] ? REM_W'(period_reg) : REM_W'(delay_reg);
                wper = period_reg;
            end
        end
        else if (cmd.eval && is_cancel && !cancel_skip)
        begin
            we = 1'b1;
        end
        else if (cmd.post && (!fire_reg || hold_per_reg != '0))
        begin
            we   = 1'b1;
            wid  = hold_id_reg;
            wper = hold_per_reg;
            wrem = fire_reg ? post_rem : hold_rem_reg;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_id[waddr]  <= wid;
            mem_rem[waddr] <= wrem;
            mem_per[waddr] <= wper;
        end
        rdata_id_reg  <= mem_id[rd_ptr_reg[IDX_W-1:0]];
        rdata_rem_reg <= mem_rem[rd_ptr_reg[IDX_W-1:0]];
        rdata_per_reg <= mem_per[rd_ptr_reg[IDX_W-1:0]];
    end

    // Transaction fields and held entry
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg    <= mode;
            delay_reg   <= delay;
            period_reg  <= period;
            cid_reg     <= cancel_id;
            elapsed_reg <= elapsed;
        end
        if (cmd.eval)
        begin
            hold_id_reg  <= rdata_id_reg;
            hold_per_reg <= rdata_per_reg;
            hold_rem_reg <= tick_rem;
        end
    end

    // Table control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            next_id_reg <= '0;
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            found_reg   <= 1'b0;
            fire_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                rd_ptr_reg <= '0;
                wr_ptr_reg <= '0;
                found_reg  <= 1'b0;
            end
            if (cmd.sched && !full)
            begin
                count_reg   <= CNT_W'(count_reg + 1'b1);
                next_id_reg <= next_id_reg + 1'b1;
            end
            if (cmd.eval)
            begin
                rd_ptr_reg <= CNT_W'(rd_ptr_reg + 1'b1);
                fire_reg   <= tick_fire;
                if (is_cancel)
                begin
                    if (cancel_skip)
                    begin
                        found_reg <= 1'b1;
                    end
                    else
                    begin
                        wr_ptr_reg <= CNT_W'(wr_ptr_reg + 1'b1);
                    end
                end
            end
            if (cmd.post && we)
            begin
                wr_ptr_reg <= CNT_W'(wr_ptr_reg + 1'b1);
            end
            if (cmd.finish)
            begin
                count_reg <= is_drain ? '0 : wr_ptr_reg;
            end
        end
    end

    // Result selection
    always_comb
    begin
        res_valid_next = 1'b0;
        res_kind_next  = ttt_pkg::KIND_DONE;
        res_id_next    = '0;
        res_found_next = 1'b0;
        res_last_next  = 1'b1;
        if (cmd.sched)
        begin
            res_valid_next = 1'b1;
            res_kind_next  = full ? ttt_pkg::KIND_FULL : ttt_pkg::KIND_SCHED;
            res_id_next    = full ? '0 : next_id_reg;
        end
        else if (cmd.eval && ((is_tick && tick_fire) || is_drain))
        begin
            res_valid_next = 1'b1;
            res_kind_next  = ttt_pkg::KIND_FIRED;
            res_id_next    = rdata_id_reg;
            res_last_next  = 1'b0;
        end
        else if (cmd.finish)
        begin
            res_valid_next = 1'b1;
            if (is_cancel)
            begin
                res_kind_next  = ttt_pkg::KIND_CANCEL;
                res_id_next    = cid_reg;
                res_found_next = found_reg;
            end
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        res_kind_reg  <= res_kind_next;
        res_id_reg    <= res_id_next;
        res_found_reg <= res_found_next;
        res_last_reg  <= res_last_next;
    end

    assign result_valid = res_valid_reg;
    assign kind         = res_kind_reg;
    assign task_id      = res_id_reg;
    assign found        = res_found_reg;
    assign last         = res_last_reg;

endmodule

### hdl/timed_task_table.sv
// Schedule: start is taken into the dispatch state, and the result register strobes after it; busy for 1 cycle.
// Cancel and drain step each live entry through a read and an eval state; tick adds a post state per entry,
// set by the single read and write port of the entry memory (N live entries, up to TABLE_DEPTH).
// Results leave on a one-cycle strobe; the receiver cannot stall.
// Reset (rst_n low, asynchronous) empties the table and restarts ids at zero.
module timed_task_table #(
    parameter int TABLE_DEPTH = ttt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic        [ttt_pkg::MODE_W-1:0]  mode,
    input  logic signed [ttt_pkg::DLY_W-1:0]   delay,
    input  logic        [ttt_pkg::PER_W-1:0]   period,
    input  logic        [ttt_pkg::ID_W-1:0]    cancel_id,
    input  logic        [ttt_pkg::PER_W-1:0]   elapsed,
    output logic                               result_valid,
    output logic        [ttt_pkg::KIND_W-1:0]  kind,
    output logic        [ttt_pkg::ID_W-1:0]    task_id,
    output logic                               found,
    output logic                               last
);

    ttt_pkg::cmd_t  cmd;
    ttt_pkg::stat_t stat;

    // Sequencer
    ttt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Entry table and result register
    ttt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode         (mode),
        .delay        (delay),
        .period       (period),
        .cancel_id    (cancel_id),
        .elapsed      (elapsed),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .kind         (kind),
        .task_id      (task_id),
        .found        (found),
        .last         (last)
    );

endmodule
